// ===== sv/mh64a_pkg.sv =====
// Package for the MurmurHash64A block: constants, sequencer and multiplier types,
// and small helper functions. No dependencies.
`default_nettype none

package mh64a_pkg;

    localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned HASH_SHIFT = 47;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NBYTES_W   = 4;
    localparam int unsigned KLEN_W     = 32;
    localparam int unsigned SEED_W     = 32;
    localparam int unsigned WORD_BYTES = 8;

    // in_tdata: data_word, bytes_valid, key_length, zero pad to whole bytes
    localparam int unsigned S_TDATA_W  = 104;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_DISPATCH,
        S_W1,
        S_W2,
        S_H,
        S_FIN,
        S_EMIT
    } t_state;

    // partial products of the low 64 bits of a * M
    typedef enum logic [1:0] {
        MS_LL,
        MS_LH,
        MS_HL
    } t_mul_step;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        xorshift = v ^ (v >> HASH_SHIFT);
    endfunction

    // keep the low nbytes bytes of a word
    function automatic logic [63:0] mask_bytes(input logic [63:0] w,
                                               input logic [NBYTES_W-1:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            if (k < int'(nbytes)) begin
                m[8*k +: 8] = 8'hff;
            end
        end
        mask_bytes = w & m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/murmur_hash_64a.sv =====
// Top level of the MurmurHash64A block: request sequencer, hash state, output register.
// Uses mh64a_pkg and the shared multiplier mh64a_mul.
`default_nettype none

// Hashes a key streamed as little-endian 64-bit words, one 64-bit result per key on the
// word marked tlast. All 64-bit products by the hash constant go through one shared
// multiplier that forms each product from three 32x32 partial products. An input
// word is accepted only once the previous word is through all of its products: one
// for the key length of a first word, three for a full 8-byte word or one for a
// partial word, and one more for a last word, which then also passes the emit state.
// A finished hash waits in an output register; the next key's words are accepted
// meanwhile, and only the next emit waits for that register to drain.
module murmur_hash_64a import mh64a_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // data_word[63:0], bytes_valid[67:64],
                                                  // key_length[99:68], zero pad
    input  wire logic [0:0]           i_s_tuser,  // first_word[0]
    input  wire logic                 i_s_tlast,  // last_word
    // hash results
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [WORD_W-1:0]    o_m_tdata,  // hash_value[63:0]
    // seed register write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SEED_W-1:0]    i_cfg_data
);

    t_state                r_state, n_state;
    logic [63:0]           r_hash, n_hash;
    logic [SEED_W-1:0]     r_seed;
    logic [63:0]           r_word, n_word;
    logic [NBYTES_W-1:0]   r_nbytes, n_nbytes;
    logic                  r_last, n_last;
    logic [63:0]           r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    logic [63:0]           r_out_data, n_out_data;

    logic                  s_accept;
    logic [NBYTES_W-1:0]   in_nbytes;
    logic                  mul_start;
    logic [63:0]           mul_operand;
    t_mul_stat             mul_stat;
    logic [63:0]           mul_product;

    mh64a_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_operand (mul_operand),
        .o_stat    (mul_stat),
        .o_product (mul_product)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // counts above eight mean a full word
    assign in_nbytes = i_s_tdata[67] ? NBYTES_W'(WORD_BYTES) : i_s_tdata[67:64];

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_word      = r_word;
        n_nbytes    = r_nbytes;
        n_last      = r_last;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mul_start   = 1'b0;
        mul_operand = 64'h0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_word   = i_s_tdata[63:0];
                    n_nbytes = in_nbytes;
                    n_last   = i_s_tlast;
                    if (i_s_tuser[0]) begin
                        mul_start   = 1'b1;
                        mul_operand = {32'h0, i_s_tdata[99:68]};
                        n_state     = S_LEN;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_LEN: begin
                if (mul_stat.done) begin
                    n_hash  = {32'h0, r_seed} ^ mul_product;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_nbytes == NBYTES_W'(WORD_BYTES)) begin
                    mul_start   = 1'b1;
                    mul_operand = r_word;
                    n_state     = S_W1;
                end else if (r_nbytes != '0) begin
                    // tail mix
                    mul_start   = 1'b1;
                    mul_operand = r_hash ^ mask_bytes(r_word, r_nbytes);
                    n_state     = S_H;
                end else if (r_last) begin
                    mul_start   = 1'b1;
                    mul_operand = xorshift(r_hash);
                    n_state     = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_W1: begin
                if (mul_stat.done) begin
                    mul_start   = 1'b1;
                    mul_operand = xorshift(mul_product);
                    n_state     = S_W2;
                end
            end
            S_W2: begin
                if (mul_stat.done) begin
                    mul_start   = 1'b1;
                    mul_operand = r_hash ^ mul_product;
                    n_state     = S_H;
                end
            end
            S_H: begin
                if (mul_stat.done) begin
                    n_hash = mul_product;
                    if (r_last) begin
                        mul_start   = 1'b1;
                        mul_operand = xorshift(mul_product);
                        n_state     = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (mul_stat.done) begin
                    n_res   = xorshift(mul_product);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= 64'h0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_nbytes   <= n_nbytes;
        r_last     <= n_last;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    // a product only completes while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == S_LEN || r_state == S_W1 || r_state == S_W2 ||
                           r_state == S_H || r_state == S_FIN))
        else $error("multiplier result outside a wait state");

    // a new product is never requested while the multiplier is busy
    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // a result appears only out of the emit state
    a_rose_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_EMIT))
        else $error("result valid without emit");

    // an accepted word moves the sequencer on at once
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_LEN || r_state == S_DISPATCH))
        else $error("accepted request not processed");
`endif

endmodule

`default_nettype wire

// ===== sv/mh64a_mul.sv =====
// Iterative multiply by the hash constant, low 64 bits of the product.
// One 32x32 multiplier, three partial products in turn. Uses mh64a_pkg.
`default_nettype none

module mh64a_mul import mh64a_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_operand,
    output t_mul_stat        o_stat,
    output logic      [63:0] o_product
);

    logic        r_busy;
    logic        r_done;
    t_mul_step   r_step;
    logic [63:0] r_a;
    logic [63:0] r_acc;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] n_acc;

    always_comb begin
        mul_x = (r_step == MS_HL) ? r_a[63:32] : r_a[31:0];
        mul_y = (r_step == MS_LH) ? HASH_MUL[63:32] : HASH_MUL[31:0];
        mul_p = {32'h0, mul_x} * {32'h0, mul_y};
        case (r_step)
            MS_LL:   n_acc = mul_p;
            MS_LH:   n_acc = r_acc + {mul_p[31:0], 32'h0};
            MS_HL:   n_acc = r_acc + {mul_p[31:0], 32'h0};
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= MS_LL;
        end else begin
            r_done <= r_busy && (r_step == MS_HL);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= MS_LL;
            end else if (r_busy) begin
                case (r_step)
                    MS_LL:   r_step <= MS_LH;
                    MS_LH:   r_step <= MS_HL;
                    MS_HL:   r_busy <= 1'b0;
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_operand;
        end
        if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_stat    = '{busy: r_busy, done: r_done};
    assign o_product = r_acc;

endmodule

`default_nettype wire
